// File: rtl/core/ptom_pkg.sv
// Shared types, codes and default sizes of the order book matcher.
package ptom_pkg;

    localparam int DEF_MAX_ORDERS = 32;
    localparam int DEF_PRICE_BITS = 32;
    localparam int DEF_QTY_BITS   = 32;
    localparam int DEF_ID_BITS    = 32;

    localparam logic [1:0] OP_LIMIT  = 2'd0;
    localparam logic [1:0] OP_MARKET = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_RESTING   = 3'd0;
    localparam logic [2:0] ST_PARTIAL   = 3'd1;
    localparam logic [2:0] ST_FILLED    = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_BOOK_FULL = 3'd5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [31:0] order_tag;
        logic [31:0] user_id;
    } order_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] trade_price;
        logic [31:0] trade_quantity;
        logic [31:0] buy_order;
        logic [31:0] sell_order;
        logic [31:0] buyer;
        logic [31:0] seller;
        logic [2:0]  status;
        logic        last;
    } result_t;

endpackage

// File: rtl/core/ptom_stream_if.sv
// Valid/ready channel carrying one payload beat.
interface ptom_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/ptom_cell.sv
// One book slot: holds a resting order and folds it into the passing search token.
module ptom_cell #(
    parameter int MAX_ORDERS = 32,
    parameter int PRICE_BITS = 32,
    parameter int QTY_BITS   = 32,
    parameter int ID_BITS    = 32,
    parameter int MY_IDX     = 0,
    parameter type cand_t    = logic,
    parameter type cmd_t     = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  cand_t cand_in,
    input  cmd_t  cmd,
    output cand_t cand_out
);
    import ptom_pkg::*;

    localparam int IW = $clog2(MAX_ORDERS);
    localparam logic [IW-1:0] MY = IW'(MY_IDX);

    logic                  valid_reg, valid_next;
    logic                  side_reg, side_next;
    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [QTY_BITS-1:0]   rem_reg, rem_next;
    logic [ID_BITS-1:0]    oid_reg, oid_next;
    logic [ID_BITS-1:0]    uid_reg, uid_next;
    logic [31:0]           arr_reg, arr_next;
    cand_t                 cand_reg, cand_next;

    logic        eligible;
    logic        better;
    logic [31:0] age;

    always_comb
    begin
        age = cmd.ctr - arr_reg;
        eligible = valid_reg && (side_reg != cmd.tside);
        if (cmd.use_limit)
        begin
            if (cmd.tside == SIDE_BUY)
                eligible = eligible && (price_reg <= cmd.limit);
            else
                eligible = eligible && (price_reg >= cmd.limit);
        end
        if (!cand_in.found)
            better = 1'b1;
        else if (price_reg != cand_in.price)
            better = (cmd.tside == SIDE_BUY) ? (price_reg < cand_in.price)
                                              : (price_reg > cand_in.price);
        else
            better = age > cand_in.age;

        cand_next = cand_in;
        if (eligible && better)
        begin
            cand_next.found = 1'b1;
            cand_next.idx   = MY;
            cand_next.price = price_reg;
            cand_next.age   = age;
            cand_next.rem   = rem_reg;
            cand_next.oid   = oid_reg;
            cand_next.uid   = uid_reg;
        end
        if (!valid_reg && !cand_in.free_found)
        begin
            cand_next.free_found = 1'b1;
            cand_next.free_idx   = MY;
        end

        valid_next = valid_reg;
        side_next  = side_reg;
        price_next = price_reg;
        rem_next   = rem_reg;
        oid_next   = oid_reg;
        uid_next   = uid_reg;
        arr_next   = arr_reg;

        if (cmd.cancel && cand_in.live && valid_reg && (oid_reg == cmd.oid))
        begin
            valid_next    = 1'b0;
            cand_next.hit = 1'b1;
        end
        if (cmd.fill && (cmd.idx == MY))
        begin
            rem_next = rem_reg - cmd.qty;
            if (rem_reg == cmd.qty)
                valid_next = 1'b0;
        end
        if (cmd.ins && (cmd.idx == MY))
        begin
            valid_next = 1'b1;
            side_next  = cmd.tside;
            price_next = cmd.limit;
            rem_next   = cmd.qty;
            oid_next   = cmd.oid;
            uid_next   = cmd.uid;
            arr_next   = cmd.ctr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cand_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cand_reg  <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg  <= side_next;
        price_reg <= price_next;
        rem_reg   <= rem_next;
        oid_reg   <= oid_next;
        uid_reg   <= uid_next;
        arr_reg   <= arr_next;
    end

    assign cand_out = cand_reg;

endmodule

// File: rtl/core/price_time_order_matcher.sv
// Price-time priority order book matcher: controller and row of book slots.
// Each fill takes a search sweep through the row of slots and then a trade beat, which waits
// while the output is stalled; an item ends with one more sweep unless its last fill completes
// it, and a cancel takes a single sweep before its status beat.
// One item is in work at a time; the next is accepted while the final status beat waits.
// Reset (asynchronous, active low) empties the book and clears the arrival counter.
module price_time_order_matcher #(
    parameter int MAX_ORDERS = ptom_pkg::DEF_MAX_ORDERS,
    parameter int PRICE_BITS = ptom_pkg::DEF_PRICE_BITS,
    parameter int QTY_BITS   = ptom_pkg::DEF_QTY_BITS,
    parameter int ID_BITS    = ptom_pkg::DEF_ID_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    ptom_stream_if.sink   orders,
    ptom_stream_if.source results
);
    import ptom_pkg::*;

    localparam int IW = $clog2(MAX_ORDERS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_TRADE  = 3'd2;
    localparam logic [2:0] S_FINAL  = 3'd3;

    typedef struct packed {
        logic                  live;
        logic                  found;
        logic                  hit;
        logic                  free_found;
        logic [IW-1:0]         idx;
        logic [IW-1:0]         free_idx;
        logic [PRICE_BITS-1:0] price;
        logic [31:0]           age;
        logic [QTY_BITS-1:0]   rem;
        logic [ID_BITS-1:0]    oid;
        logic [ID_BITS-1:0]    uid;
    } cand_t;

    typedef struct packed {
        logic                  tside;
        logic                  use_limit;
        logic                  fill;
        logic                  cancel;
        logic                  ins;
        logic [IW-1:0]         idx;
        logic [PRICE_BITS-1:0] limit;
        logic [QTY_BITS-1:0]   qty;
        logic [ID_BITS-1:0]    oid;
        logic [ID_BITS-1:0]    uid;
        logic [31:0]           ctr;
    } cmd_t;

    logic [2:0]            state_reg, state_next;
    logic                  cancel_reg, cancel_next;
    logic                  limit_reg, limit_next;
    logic                  side_reg, side_next;
    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [QTY_BITS-1:0]   rem_reg, rem_next;
    logic [ID_BITS-1:0]    id_reg, id_next;
    logic [ID_BITS-1:0]    uid_reg, uid_next;
    logic                  any_fill_reg, any_fill_next;
    logic                  start_reg, start_next;
    logic [31:0]           ctr_reg, ctr_next;
    logic [2:0]            status_reg, status_next;
    logic [PRICE_BITS-1:0] tprice_reg, tprice_next;
    logic [QTY_BITS-1:0]   ex_reg, ex_next;
    logic [IW-1:0]         fidx_reg, fidx_next;
    logic [ID_BITS-1:0]    moid_reg, moid_next;
    logic [ID_BITS-1:0]    muid_reg, muid_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_data_reg, out_data_next;

    cand_t                 chain [MAX_ORDERS+1];
    cand_t                 head;
    cand_t                 best;
    cmd_t                  cmd;
    logic                  out_free;
    logic [QTY_BITS-1:0]   ex;
    logic                  accept;

    assign accept   = orders.valid && orders.ready;
    assign out_free = !out_valid_reg || results.ready;
    assign best     = chain[MAX_ORDERS];
    assign ex       = (rem_reg < best.rem) ? rem_reg : best.rem;

    always_comb
    begin
        head      = '0;
        head.live = start_reg;
    end

    assign chain[0] = head;

    for (genvar g = 0; g < MAX_ORDERS; g++)
    begin : g_cell
        ptom_cell #(
            .MAX_ORDERS (MAX_ORDERS),
            .PRICE_BITS (PRICE_BITS),
            .QTY_BITS   (QTY_BITS),
            .ID_BITS    (ID_BITS),
            .MY_IDX     (g),
            .cand_t     (cand_t),
            .cmd_t      (cmd_t)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cand_in  (chain[g]),
            .cmd      (cmd),
            .cand_out (chain[g+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        cancel_next    = cancel_reg;
        limit_next     = limit_reg;
        side_next      = side_reg;
        price_next     = price_reg;
        rem_next       = rem_reg;
        id_next        = id_reg;
        uid_next       = uid_reg;
        any_fill_next  = any_fill_reg;
        start_next     = 1'b0;
        ctr_next       = ctr_reg;
        status_next    = status_reg;
        tprice_next    = tprice_reg;
        ex_next        = ex_reg;
        fidx_next      = fidx_reg;
        moid_next      = moid_reg;
        muid_next      = muid_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_data_next  = out_data_reg;

        cmd           = '0;
        cmd.tside     = side_reg;
        cmd.use_limit = limit_reg;
        cmd.limit     = price_reg;
        cmd.oid       = id_reg;
        cmd.uid       = uid_reg;
        cmd.ctr       = ctr_reg;
        cmd.cancel    = (state_reg == S_SEARCH) && cancel_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cancel_next   = orders.data.opcode == OP_CANCEL;
                    limit_next    = orders.data.opcode == OP_LIMIT;
                    side_next     = orders.data.side;
                    price_next    = PRICE_BITS'(orders.data.price);
                    rem_next      = QTY_BITS'(orders.data.quantity);
                    id_next       = ID_BITS'(orders.data.order_tag);
                    uid_next      = ID_BITS'(orders.data.user_id);
                    any_fill_next = 1'b0;
                    if (orders.data.opcode == OP_CANCEL)
                    begin
                        start_next = 1'b1;
                        state_next = S_SEARCH;
                    end
                    else if (orders.data.opcode != OP_LIMIT &&
                             orders.data.opcode != OP_MARKET)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_FINAL;
                    end
                    else if (QTY_BITS'(orders.data.quantity) == '0)
                    begin
                        status_next = ST_FILLED;
                        state_next  = S_FINAL;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (best.live)
                begin
                    if (cancel_reg)
                    begin
                        status_next = best.hit ? ST_CANCELLED : ST_NOT_FOUND;
                        state_next  = S_FINAL;
                    end
                    else if (best.found)
                    begin
                        tprice_next   = best.price;
                        ex_next       = ex;
                        fidx_next     = best.idx;
                        moid_next     = best.oid;
                        muid_next     = best.uid;
                        rem_next      = rem_reg - ex;
                        any_fill_next = 1'b1;
                        state_next    = S_TRADE;
                    end
                    else if (!limit_reg)
                    begin
                        status_next = ST_PARTIAL;
                        state_next  = S_FINAL;
                    end
                    else if (best.free_found)
                    begin
                        cmd.ins     = 1'b1;
                        cmd.idx     = best.free_idx;
                        cmd.qty     = rem_reg;
                        ctr_next    = ctr_reg + 32'd1;
                        status_next = any_fill_reg ? ST_PARTIAL : ST_RESTING;
                        state_next  = S_FINAL;
                    end
                    else
                    begin
                        status_next = ST_BOOK_FULL;
                        state_next  = S_FINAL;
                    end
                end
            end
            S_TRADE:
            begin
                if (out_free)
                begin
                    cmd.fill                     = 1'b1;
                    cmd.idx                      = fidx_reg;
                    cmd.qty                      = ex_reg;
                    out_valid_next               = 1'b1;
                    out_data_next                = '0;
                    out_data_next.kind           = KIND_TRADE;
                    out_data_next.trade_price    = 32'(tprice_reg);
                    out_data_next.trade_quantity = 32'(ex_reg);
                    if (side_reg == SIDE_BUY)
                    begin
                        out_data_next.buy_order  = 32'(id_reg);
                        out_data_next.sell_order = 32'(moid_reg);
                        out_data_next.buyer      = 32'(uid_reg);
                        out_data_next.seller     = 32'(muid_reg);
                    end
                    else
                    begin
                        out_data_next.buy_order  = 32'(moid_reg);
                        out_data_next.sell_order = 32'(id_reg);
                        out_data_next.buyer      = 32'(muid_reg);
                        out_data_next.seller     = 32'(uid_reg);
                    end
                    if (rem_reg == '0)
                    begin
                        status_next = ST_FILLED;
                        state_next  = S_FINAL;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = S_SEARCH;
                    end
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next        = '0;
                    out_data_next.kind   = KIND_STATUS;
                    out_data_next.status = status_reg;
                    out_data_next.last   = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cancel_reg   <= cancel_next;
        limit_reg    <= limit_next;
        side_reg     <= side_next;
        price_reg    <= price_next;
        rem_reg      <= rem_next;
        id_reg       <= id_next;
        uid_reg      <= uid_next;
        any_fill_reg <= any_fill_next;
        status_reg   <= status_next;
        tprice_reg   <= tprice_next;
        ex_reg       <= ex_next;
        fidx_reg     <= fidx_next;
        moid_reg     <= moid_next;
        muid_reg     <= muid_next;
        out_data_reg <= out_data_next;
    end

    assign orders.ready  = state_reg == S_IDLE;
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

endmodule
